FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros shared by the envelope design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

FILE: design/pte_pkg.sv
// ----------------------------------------------------------------------------
// pte_pkg
// Types, constants and helper functions for the actuator envelope block.
// ----------------------------------------------------------------------------
package pte_pkg;

    localparam int unsigned FIN_UNITS_DEF     = 3;
    localparam int unsigned CRICKET_UNITS_DEF = 3;

    localparam logic [31:0] FIN_UP_END    = 32'd1000;
    localparam logic [31:0] FIN_HOLD_END  = 32'd1500;
    localparam logic [31:0] CRK_UP_END    = 32'd3000;
    localparam logic [31:0] CRK_HOLD_END  = 32'd4000;
    localparam logic [31:0] CRK_JOIN1     = 32'd500;
    localparam logic [31:0] CRK_JOIN2     = 32'd1000;
    localparam logic [31:0] CRK_JOIN3     = 32'd1500;
    localparam logic [31:0] TENTH_MS      = 32'd100;

    localparam logic [15:0] FIN_GAP_START = 16'd2;
    localparam logic [15:0] CRK_GAP_START = 16'd1;
    localparam logic [15:0] GAP_MAX       = 16'hFFFF;

    localparam logic [1:0] ARM_PAT_CROSS = 2'd0;
    localparam logic [1:0] ARM_PAT_WIRE0 = 2'd1;
    localparam logic [1:0] ARM_PAT_WIRE1 = 2'd2;
    localparam logic [1:0] ARM_PAT_IDLE  = 2'd3;

    localparam logic KIND_FIN     = 1'b0;
    localparam logic KIND_CRICKET = 1'b1;

    localparam logic [15:0] RST_TRIGGER_LEVEL   = 16'd1200;
    localparam logic [7:0]  RST_LIGHT_CEILING   = 8'd255;
    localparam logic [7:0]  RST_MOTOR_CEILING   = 8'd150;
    localparam logic [7:0]  RST_CRICKET_CEILING = 8'd150;
    localparam logic [15:0] RST_ARM_TENTHS      = 16'd10;

    typedef enum logic [2:0] {
        CFG_TRIGGER_LEVEL   = 3'd0,
        CFG_LIGHT_CEILING   = 3'd1,
        CFG_MOTOR_CEILING   = 3'd2,
        CFG_CRICKET_CEILING = 3'd3,
        CFG_WIRE_FIRST_MAX  = 3'd4,
        CFG_WIRE_SECOND_MAX = 3'd5,
        CFG_ARM_ON_TENTHS   = 3'd6,
        CFG_ARM_OFF_TENTHS  = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] trigger_level;
        logic [7:0]  light_ceiling;
        logic [7:0]  motor_ceiling;
        logic [7:0]  cricket_ceiling;
        logic [7:0]  wire_first_max;
        logic [7:0]  wire_second_max;
        logic [15:0] arm_on_tenths;
        logic [15:0] arm_off_tenths;
    } cfg_t;

    typedef struct packed {
        logic        command;
        logic [1:0]  unit;
        logic [31:0] now_ms;
        logic [15:0] sensor_a;
        logic [15:0] sensor_b;
    } upd_t;

    typedef struct packed {
        logic        kind_echo;
        logic [1:0]  unit_echo;
        logic [7:0]  drive_0;
        logic [7:0]  drive_1;
        logic [7:0]  drive_2;
        logic [7:0]  drive_3;
        logic [7:0]  wire_0_level;
        logic [7:0]  wire_1_level;
        logic        arm_active;
        logic        ramp_active;
    } res_t;

    typedef struct packed {
        logic [7:0] light;
        logic [7:0] motor;
        logic [7:0] wire_0;
        logic [7:0] wire_1;
        logic       arm_active;
        logic       ramp_active;
    } fin_view_t;

    typedef logic [3:0][7:0] crk_levels_t;

    typedef struct packed {
        crk_levels_t levels;
        logic        ramp_active;
    } crk_view_t;

    function automatic logic [7:0] up_to(input logic [7:0] lv, input logic [7:0] ceiling);
        return (lv < ceiling) ? lv + 8'd1 : lv;
    endfunction

    function automatic logic [7:0] down_to_zero(input logic [7:0] lv);
        return (lv != 8'd0) ? lv - 8'd1 : lv;
    endfunction

    function automatic logic [15:0] gap_inc(input logic [15:0] gap);
        return (gap == GAP_MAX) ? gap : gap + 16'd1;
    endfunction

endpackage

FILE: design/pte_fin_bank.sv
// ----------------------------------------------------------------------------
// pte_fin_bank
// Per-unit state of the fin units: actuator cycle and light/motor ramp.
// ----------------------------------------------------------------------------
module pte_fin_bank #(
    parameter int unsigned FIN_UNITS = pte_pkg::FIN_UNITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  pte_pkg::upd_t      upd,
    input  pte_pkg::cfg_t      cfg,
    output pte_pkg::fin_view_t view
);

    localparam int unsigned UIDX_W = (FIN_UNITS > 1) ? $clog2(FIN_UNITS) : 1;

    logic [UIDX_W+1:0] unit_wide;
    logic [UIDX_W-1:0] idx;
    logic              in_range;

    logic        arm_run_reg   [FIN_UNITS];
    logic [1:0]  arm_pat_reg   [FIN_UNITS];
    logic [31:0] arm_start_reg [FIN_UNITS];
    logic        arm_fw_reg    [FIN_UNITS];
    logic        arm_sw_reg    [FIN_UNITS];
    logic [1:0][7:0] wire_reg  [FIN_UNITS];
    logic        ramp_run_reg  [FIN_UNITS];
    logic [31:0] ramp_start_reg[FIN_UNITS];
    logic [31:0] ramp_last_reg [FIN_UNITS];
    logic [15:0] ramp_gap_reg  [FIN_UNITS];
    logic [7:0]  light_reg     [FIN_UNITS];
    logic [7:0]  motor_reg     [FIN_UNITS];

    logic        arm_run_next;
    logic [1:0]  arm_pat_next;
    logic [31:0] arm_start_next;
    logic        arm_fw_next;
    logic        arm_sw_next;
    logic [1:0][7:0] wire_next;
    logic        ramp_run_next;
    logic [31:0] ramp_start_next;
    logic [31:0] ramp_last_next;
    logic [15:0] ramp_gap_next;
    logic [7:0]  light_next;
    logic [7:0]  motor_next;

    logic [31:0] arm_age;
    logic [31:0] arm_on_lim;
    logic [31:0] arm_total_lim;
    logic [31:0] ramp_age;
    logic        ramp_step;

    assign unit_wide = (UIDX_W+2)'(upd.unit);
    assign idx       = unit_wide[UIDX_W-1:0];
    assign in_range  = unit_wide < (UIDX_W+2)'(FIN_UNITS);

    assign arm_age       = upd.now_ms - arm_start_reg[idx];
    assign arm_on_lim    = 32'(cfg.arm_on_tenths) * pte_pkg::TENTH_MS;
    assign arm_total_lim = (32'(cfg.arm_on_tenths) + 32'(cfg.arm_off_tenths))
                           * pte_pkg::TENTH_MS;
    assign ramp_age      = upd.now_ms - ramp_start_reg[idx];
    assign ramp_step     = (upd.now_ms - ramp_last_reg[idx]) > 32'(ramp_gap_reg[idx]);

    always_comb
    begin
        arm_run_next   = arm_run_reg[idx];
        arm_pat_next   = arm_pat_reg[idx];
        arm_start_next = arm_start_reg[idx];
        arm_fw_next    = arm_fw_reg[idx];
        arm_sw_next    = arm_sw_reg[idx];
        wire_next      = wire_reg[idx];

        if (!arm_run_reg[idx] && upd.sensor_b < cfg.trigger_level
                && upd.sensor_a < cfg.trigger_level)
        begin
            wire_next    = '0;
            arm_pat_next = pte_pkg::ARM_PAT_IDLE;
        end
        else if (!arm_run_reg[idx])
        begin
            case (arm_pat_reg[idx])
                pte_pkg::ARM_PAT_WIRE0:
                begin
                    arm_fw_next = 1'b0;
                    arm_sw_next = 1'b0;
                end
                pte_pkg::ARM_PAT_WIRE1:
                begin
                    arm_fw_next = 1'b1;
                    arm_sw_next = 1'b1;
                end
                default:
                begin
                    arm_fw_next = 1'b0;
                    arm_sw_next = 1'b1;
                end
            endcase
            arm_run_next   = 1'b1;
            arm_start_next = upd.now_ms;
            wire_next[arm_fw_next] = cfg.wire_first_max;
            wire_next[arm_sw_next] = cfg.wire_second_max;
        end
        else if (arm_age > arm_total_lim)
        begin
            arm_run_next = 1'b0;
            arm_pat_next = pte_pkg::ARM_PAT_CROSS;
        end
        else if (arm_age > arm_on_lim)
        begin
            wire_next[arm_sw_reg[idx]] = 8'd0;
            wire_next[arm_fw_reg[idx]] = 8'd0;
        end
    end

    always_comb
    begin
        ramp_run_next   = ramp_run_reg[idx];
        ramp_start_next = ramp_start_reg[idx];
        ramp_last_next  = ramp_last_reg[idx];
        ramp_gap_next   = ramp_gap_reg[idx];
        light_next      = light_reg[idx];
        motor_next      = motor_reg[idx];

        if (upd.sensor_a > cfg.trigger_level && !ramp_run_reg[idx])
        begin
            ramp_run_next   = 1'b1;
            ramp_start_next = upd.now_ms;
            ramp_last_next  = upd.now_ms;
            ramp_gap_next   = pte_pkg::FIN_GAP_START;
        end
        else if (ramp_run_reg[idx])
        begin
            if (ramp_age > pte_pkg::FIN_HOLD_END)
            begin
                if (ramp_step)
                begin
                    light_next     = pte_pkg::down_to_zero(light_reg[idx]);
                    motor_next     = pte_pkg::down_to_zero(motor_reg[idx]);
                    ramp_gap_next  = pte_pkg::gap_inc(ramp_gap_reg[idx]);
                    ramp_last_next = upd.now_ms;
                end
                if (light_next == 8'd0 && motor_next == 8'd0)
                begin
                    ramp_run_next = 1'b0;
                end
            end
            else if (ramp_age <= pte_pkg::FIN_UP_END && ramp_step)
            begin
                light_next     = pte_pkg::up_to(light_reg[idx], cfg.light_ceiling);
                motor_next     = pte_pkg::up_to(motor_reg[idx], cfg.motor_ceiling);
                ramp_gap_next  = pte_pkg::gap_inc(ramp_gap_reg[idx]);
                ramp_last_next = upd.now_ms;
            end
        end
    end

    always_comb
    begin
        view = '0;
        if (in_range)
        begin
            view.light       = light_next;
            view.motor       = motor_next;
            view.wire_0      = wire_next[0];
            view.wire_1      = wire_next[1];
            view.arm_active  = arm_run_next;
            view.ramp_active = ramp_run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FIN_UNITS; i++)
            begin
                arm_run_reg[i]    <= 1'b0;
                arm_pat_reg[i]    <= pte_pkg::ARM_PAT_CROSS;
                arm_start_reg[i]  <= '0;
                arm_fw_reg[i]     <= 1'b0;
                arm_sw_reg[i]     <= 1'b1;
                wire_reg[i]       <= '0;
                ramp_run_reg[i]   <= 1'b0;
                ramp_start_reg[i] <= '0;
                ramp_last_reg[i]  <= '0;
                ramp_gap_reg[i]   <= '0;
                light_reg[i]      <= '0;
                motor_reg[i]      <= '0;
            end
        end
        else if (commit && in_range)
        begin
            arm_run_reg[idx]    <= arm_run_next;
            arm_pat_reg[idx]    <= arm_pat_next;
            arm_start_reg[idx]  <= arm_start_next;
            arm_fw_reg[idx]     <= arm_fw_next;
            arm_sw_reg[idx]     <= arm_sw_next;
            wire_reg[idx]       <= wire_next;
            ramp_run_reg[idx]   <= ramp_run_next;
            ramp_start_reg[idx] <= ramp_start_next;
            ramp_last_reg[idx]  <= ramp_last_next;
            ramp_gap_reg[idx]   <= ramp_gap_next;
            light_reg[idx]      <= light_next;
            motor_reg[idx]      <= motor_next;
        end
    end

endmodule

FILE: design/pte_crk_bank.sv
// ----------------------------------------------------------------------------
// pte_crk_bank
// Per-unit state of the cricket units: four-channel ramp envelope.
// ----------------------------------------------------------------------------
module pte_crk_bank #(
    parameter int unsigned CRICKET_UNITS = pte_pkg::CRICKET_UNITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               commit,
    input  pte_pkg::upd_t      upd,
    input  pte_pkg::cfg_t      cfg,
    output pte_pkg::crk_view_t view
);

    localparam int unsigned UIDX_W = (CRICKET_UNITS > 1) ? $clog2(CRICKET_UNITS) : 1;

    logic [UIDX_W+1:0] unit_wide;
    logic [UIDX_W-1:0] idx;
    logic              in_range;

    logic                 run_reg   [CRICKET_UNITS];
    logic [31:0]          start_reg [CRICKET_UNITS];
    logic [31:0]          last_reg  [CRICKET_UNITS];
    logic [15:0]          gap_reg   [CRICKET_UNITS];
    pte_pkg::crk_levels_t levels_reg[CRICKET_UNITS];

    logic                 run_next;
    logic [31:0]          start_next;
    logic [31:0]          last_next;
    logic [15:0]          gap_next;
    pte_pkg::crk_levels_t levels_next;

    logic [31:0] age;
    logic        step;
    logic [3:0]  joined;

    assign unit_wide = (UIDX_W+2)'(upd.unit);
    assign idx       = unit_wide[UIDX_W-1:0];
    assign in_range  = unit_wide < (UIDX_W+2)'(CRICKET_UNITS);

    assign age    = upd.now_ms - start_reg[idx];
    assign step   = (upd.now_ms - last_reg[idx]) > 32'(gap_reg[idx]);
    assign joined = {age > pte_pkg::CRK_JOIN3, age > pte_pkg::CRK_JOIN2,
                     age > pte_pkg::CRK_JOIN1, 1'b1};

    always_comb
    begin
        run_next    = run_reg[idx];
        start_next  = start_reg[idx];
        last_next   = last_reg[idx];
        gap_next    = gap_reg[idx];
        levels_next = levels_reg[idx];

        if (upd.sensor_a > cfg.trigger_level && !run_reg[idx])
        begin
            run_next   = 1'b1;
            start_next = upd.now_ms;
            last_next  = upd.now_ms;
            gap_next   = pte_pkg::CRK_GAP_START;
        end
        else if (run_reg[idx])
        begin
            if (age > pte_pkg::CRK_HOLD_END)
            begin
                if (step)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        levels_next[k] = pte_pkg::down_to_zero(levels_reg[idx][k]);
                    end
                    gap_next  = pte_pkg::gap_inc(gap_reg[idx]);
                    last_next = upd.now_ms;
                end
                if (levels_next == '0)
                begin
                    run_next = 1'b0;
                end
            end
            else if (age <= pte_pkg::CRK_UP_END && step)
            begin
                // Channels gain one, joined ones a second, up to the ceiling.
                for (int k = 0; k < 4; k++)
                begin
                    levels_next[k] = pte_pkg::up_to(levels_reg[idx][k], cfg.cricket_ceiling);
                    if (joined[k])
                    begin
                        levels_next[k] = pte_pkg::up_to(levels_next[k], cfg.cricket_ceiling);
                    end
                end
                gap_next  = pte_pkg::gap_inc(gap_reg[idx]);
                last_next = upd.now_ms;
            end
        end
    end

    always_comb
    begin
        view = '0;
        if (in_range)
        begin
            view.levels      = levels_next;
            view.ramp_active = run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CRICKET_UNITS; i++)
            begin
                run_reg[i]    <= 1'b0;
                start_reg[i]  <= '0;
                last_reg[i]   <= '0;
                gap_reg[i]    <= '0;
                levels_reg[i] <= '0;
            end
        end
        else if (commit && in_range)
        begin
            run_reg[idx]    <= run_next;
            start_reg[idx]  <= start_next;
            last_reg[idx]   <= last_next;
            gap_reg[idx]    <= gap_next;
            levels_reg[idx] <= levels_next;
        end
    end

endmodule

FILE: design/proximity_triggered_actuator_envelope.sv
// ----------------------------------------------------------------------------
// proximity_triggered_actuator_envelope
// Proximity-triggered actuator cycle and ramp envelope for fin and cricket
// units.
// ----------------------------------------------------------------------------
// Each update item on the upd channel carries a command (fin or cricket), a
// unit index, the millisecond time and the IR readings. For every accepted
// item exactly one result item leaves on the res channel, in order, carrying
// the unit's drive levels after the update.
// An accepted item is held in an input register; when the output register
// can advance, the selected unit's state is read, updated and written back
// while the result is captured in the output register. One item is taken
// every cycle while the receiver does not stall.
// The state update for consecutive items on the same unit is chained through
// the unit registers, so no item waits on the one before it.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; further items wait on upd_ready.
// Configuration writes on cfg_we take effect at the next edge and must only
// be made while no item is in flight.
// Reset returns the configuration, the valid flags and all unit state to their reset values at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module proximity_triggered_actuator_envelope #(
    parameter int unsigned FIN_UNITS     = pte_pkg::FIN_UNITS_DEF,
    parameter int unsigned CRICKET_UNITS = pte_pkg::CRICKET_UNITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          upd_valid,
    output logic          upd_ready,
    input  pte_pkg::upd_t upd,
    output logic          res_valid,
    input  logic          res_ready,
    output pte_pkg::res_t res,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [15:0]   cfg_wdata
);

    pte_pkg::cfg_t cfg_reg;
    pte_pkg::cfg_t cfg_next;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    pte_pkg::upd_t s1_reg;
    logic          res_valid_reg;
    logic          res_valid_next;
    pte_pkg::res_t res_reg;
    pte_pkg::res_t res_next;

    logic advance;
    logic fin_commit;
    logic crk_commit;

    pte_pkg::fin_view_t fin_view;
    pte_pkg::crk_view_t crk_view;

    assign advance    = !res_valid_reg || res_ready;
    assign upd_ready  = !s1_valid_reg || advance;
    assign fin_commit = s1_valid_reg && advance && s1_reg.command == pte_pkg::KIND_FIN;
    assign crk_commit = s1_valid_reg && advance && s1_reg.command == pte_pkg::KIND_CRICKET;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (pte_pkg::cfg_index_t'(cfg_addr))
                pte_pkg::CFG_TRIGGER_LEVEL:   cfg_next.trigger_level   = cfg_wdata;
                pte_pkg::CFG_LIGHT_CEILING:   cfg_next.light_ceiling   = cfg_wdata[7:0];
                pte_pkg::CFG_MOTOR_CEILING:   cfg_next.motor_ceiling   = cfg_wdata[7:0];
                pte_pkg::CFG_CRICKET_CEILING: cfg_next.cricket_ceiling = cfg_wdata[7:0];
                pte_pkg::CFG_WIRE_FIRST_MAX:  cfg_next.wire_first_max  = cfg_wdata[7:0];
                pte_pkg::CFG_WIRE_SECOND_MAX: cfg_next.wire_second_max = cfg_wdata[7:0];
                pte_pkg::CFG_ARM_ON_TENTHS:   cfg_next.arm_on_tenths   = cfg_wdata;
                pte_pkg::CFG_ARM_OFF_TENTHS:  cfg_next.arm_off_tenths  = cfg_wdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    pte_fin_bank #(
        .FIN_UNITS (FIN_UNITS)
    ) u_fin (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (fin_commit),
        .upd    (s1_reg),
        .cfg    (cfg_reg),
        .view   (fin_view)
    );

    pte_crk_bank #(
        .CRICKET_UNITS (CRICKET_UNITS)
    ) u_crk (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (crk_commit),
        .upd    (s1_reg),
        .cfg    (cfg_reg),
        .view   (crk_view)
    );

    always_comb
    begin
        res_next           = '0;
        res_next.kind_echo = s1_reg.command;
        res_next.unit_echo = s1_reg.unit;
        if (s1_reg.command == pte_pkg::KIND_FIN)
        begin
            res_next.drive_0      = fin_view.light;
            res_next.drive_1      = fin_view.motor;
            res_next.wire_0_level = fin_view.wire_0;
            res_next.wire_1_level = fin_view.wire_1;
            res_next.arm_active   = fin_view.arm_active;
            res_next.ramp_active  = fin_view.ramp_active;
        end
        else
        begin
            res_next.drive_0     = crk_view.levels[0];
            res_next.drive_1     = crk_view.levels[1];
            res_next.drive_2     = crk_view.levels[2];
            res_next.drive_3     = crk_view.levels[3];
            res_next.ramp_active = crk_view.ramp_active;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (upd_valid && upd_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        res_valid_next = advance ? s1_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_level   <= pte_pkg::RST_TRIGGER_LEVEL;
            cfg_reg.light_ceiling   <= pte_pkg::RST_LIGHT_CEILING;
            cfg_reg.motor_ceiling   <= pte_pkg::RST_MOTOR_CEILING;
            cfg_reg.cricket_ceiling <= pte_pkg::RST_CRICKET_CEILING;
            cfg_reg.wire_first_max  <= '0;
            cfg_reg.wire_second_max <= '0;
            cfg_reg.arm_on_tenths   <= pte_pkg::RST_ARM_TENTHS;
            cfg_reg.arm_off_tenths  <= pte_pkg::RST_ARM_TENTHS;
            s1_valid_reg            <= 1'b0;
            res_valid_reg           <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_valid && upd_ready)
        begin
            s1_reg <= upd;
        end
        if (advance && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    `ASSERT_CLK(a_stall_blocks_entry,
        (s1_valid_reg && res_valid_reg && !res_ready) |-> !upd_ready,
        "Input taken while both stages are full and the output is stalled.")

    `ASSERT_CLK(a_idle_ramp_levels_zero,
        (res_valid_reg && !res_reg.ramp_active)
            |-> (res_reg.drive_0 == 8'd0 && res_reg.drive_1 == 8'd0
                 && res_reg.drive_2 == 8'd0 && res_reg.drive_3 == 8'd0),
        "A unit without a running ramp reports a non-zero level.")

    `ASSERT_NEVER(a_cricket_no_arm,
        res_valid_reg && res_reg.kind_echo == pte_pkg::KIND_CRICKET
            && (res_reg.arm_active || res_reg.wire_0_level != 8'd0
                || res_reg.wire_1_level != 8'd0),
        "A cricket result carries actuator drive.")

    `ASSERT_CLK(a_drain_empties_output,
        (res_valid_reg && res_ready && !s1_valid_reg) |=> !res_valid_reg,
        "Output stays valid after its item left with nothing behind it.")

endmodule
